/* design/bdwr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bag draw package
// Shared sizes, controller states and control structs for the bag randomiser.
// ----------------------------------------------------------------------------
package bdwr_pkg;

  localparam int MaxBag    = 8;
  localparam int MaxQueue  = 8;
  localparam int SymW      = 3;
  localparam int RndW      = 16;
  localparam int CfgW      = 4;
  localparam int CfgIdxW   = 1;
  localparam int CntW      = $clog2(MaxBag + 1);
  localparam int QCntW     = $clog2(MaxQueue + 1);
  localparam int DivSteps  = RndW / 2;
  localparam int DivCntW   = $clog2(DivSteps);
  localparam int PlainMod  = 7;

  localparam logic [CfgIdxW-1:0] RegBagSize     = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegQueueLength = CfgIdxW'(1);

  localparam logic [CfgW-1:0] BagSizeReset     = CfgW'(7);
  localparam logic [CfgW-1:0] QueueLengthReset = CfgW'(5);

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StDone
  } ctrl_state_e;

  typedef struct packed {
    logic start;
    logic div_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } ctrl_stat_t;

endpackage

/* design/bdwr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bag draw controller
// Sequences one draw: accept, remainder iterations, then selection and issue.
// ----------------------------------------------------------------------------
module bdwr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  bdwr_pkg::ctrl_stat_t  stat_i,
  output bdwr_pkg::ctrl_cmd_t   cmd_o
);

  bdwr_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdwr_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bdwr_pkg::StIdle: begin
        if (in_valid_i) state_d = bdwr_pkg::StDiv;
      end
      bdwr_pkg::StDiv: begin
        if (stat_i.div_last) state_d = bdwr_pkg::StDone;
      end
      bdwr_pkg::StDone: begin
        if (stat_i.out_free) state_d = bdwr_pkg::StIdle;
      end
      default: state_d = bdwr_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      bdwr_pkg::StIdle: begin
        in_stall_o   = 1'b0;
        cmd_o.start  = in_valid_i;
      end
      bdwr_pkg::StDiv: begin
        cmd_o.div_step = 1'b1;
      end
      bdwr_pkg::StDone: begin
        cmd_o.finish = stat_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

/* design/bdwr_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bag draw datapath
// Configuration, radix-4 remainder unit, bag mask, preview queue and output.
// ----------------------------------------------------------------------------
module bdwr_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bdwr_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bdwr_pkg::CfgW-1:0]         cfg_wdata_i,
  input  logic [bdwr_pkg::RndW-1:0]         random_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bdwr_pkg::SymW-1:0]         symbol_o,
  input  bdwr_pkg::ctrl_cmd_t               cmd_i,
  output bdwr_pkg::ctrl_stat_t              stat_o
);

  logic [bdwr_pkg::CfgW-1:0]     bag_size_q, queue_length_q;
  logic [bdwr_pkg::MaxBag-1:0]   mask_q, mask_d;
  logic [bdwr_pkg::CntW-1:0]     count_q, count_d;
  logic [bdwr_pkg::SymW-1:0]     queue_q [bdwr_pkg::MaxQueue];
  logic [bdwr_pkg::SymW-1:0]     queue_d [bdwr_pkg::MaxQueue];
  logic [bdwr_pkg::RndW-1:0]     dividend_q;
  logic [bdwr_pkg::CntW-1:0]     divisor_q, rem_q, rem_d;
  logic [bdwr_pkg::DivCntW-1:0]  div_cnt_q;
  logic                          plain_q;
  logic                          out_valid_q;
  logic [bdwr_pkg::SymW-1:0]     symbol_q;

  logic [bdwr_pkg::CntW-1:0]     eff_bag;
  logic [bdwr_pkg::QCntW-1:0]    eff_q;
  logic [bdwr_pkg::MaxBag-1:0]   full_mask;
  logic [bdwr_pkg::CntW:0]       r1, r2;
  logic [bdwr_pkg::CntW-1:0]     pick;
  logic                          found;
  logic [bdwr_pkg::SymW-1:0]     drawn;
  logic [bdwr_pkg::SymW-1:0]     issued;

  always_comb begin
    if (int'(bag_size_q) > bdwr_pkg::MaxBag) begin
      eff_bag = bdwr_pkg::CntW'(bdwr_pkg::MaxBag);
    end else begin
      eff_bag = bdwr_pkg::CntW'(bag_size_q);
    end
    if (int'(queue_length_q) > bdwr_pkg::MaxQueue) begin
      eff_q = bdwr_pkg::QCntW'(bdwr_pkg::MaxQueue);
    end else begin
      eff_q = bdwr_pkg::QCntW'(queue_length_q);
    end
    for (int i = 0; i < bdwr_pkg::MaxBag; i++) begin
      full_mask[i] = (i < int'(eff_bag));
    end
  end

  // Two restoring remainder steps per cycle; the remainder stays below the divisor.
  always_comb begin
    r1 = {rem_q, dividend_q[bdwr_pkg::RndW-1]};
    if (r1 >= {1'b0, divisor_q}) r1 = r1 - {1'b0, divisor_q};
    r2 = {r1[bdwr_pkg::CntW-1:0], dividend_q[bdwr_pkg::RndW-2]};
    if (r2 >= {1'b0, divisor_q}) r2 = r2 - {1'b0, divisor_q};
    rem_d = r2[bdwr_pkg::CntW-1:0];
  end

  assign stat_o.div_last = (div_cnt_q == bdwr_pkg::DivCntW'(bdwr_pkg::DivSteps - 1));
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    pick   = rem_q;
    found  = 1'b0;
    drawn  = '0;
    mask_d = mask_q;
    for (int i = 0; i < bdwr_pkg::MaxBag; i++) begin
      if (!found && (i < int'(eff_bag)) && mask_q[i]) begin
        if (pick == '0) begin
          found     = 1'b1;
          drawn     = bdwr_pkg::SymW'(i);
          mask_d[i] = 1'b0;
        end else begin
          pick = pick - bdwr_pkg::CntW'(1);
        end
      end
    end
    count_d = count_q - bdwr_pkg::CntW'(1);
  end

  always_comb begin
    issued = queue_q[0];
    for (int j = 0; j < bdwr_pkg::MaxQueue; j++) begin
      if (j + 1 < int'(eff_q)) begin
        queue_d[j] = queue_q[j + 1];
      end else if (j + 1 == int'(eff_q)) begin
        queue_d[j] = drawn;
      end else begin
        queue_d[j] = queue_q[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bag_size_q     <= bdwr_pkg::BagSizeReset;
      queue_length_q <= bdwr_pkg::QueueLengthReset;
      mask_q         <= '0;
      count_q        <= '0;
      for (int j = 0; j < bdwr_pkg::MaxQueue; j++) queue_q[j] <= '0;
      div_cnt_q      <= '0;
      plain_q        <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bdwr_pkg::RegBagSize:     bag_size_q     <= cfg_wdata_i;
          bdwr_pkg::RegQueueLength: queue_length_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.start) begin
        div_cnt_q <= '0;
        plain_q   <= (bag_size_q == '0);
        if ((bag_size_q != '0) && (count_q == '0)) begin
          mask_q  <= full_mask;
          count_q <= eff_bag;
        end
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + bdwr_pkg::DivCntW'(1);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        if (!plain_q) begin
          mask_q  <= mask_d;
          count_q <= count_d;
          if (eff_q != '0) begin
            for (int j = 0; j < bdwr_pkg::MaxQueue; j++) queue_q[j] <= queue_d[j];
          end
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      dividend_q <= random_value_i;
      rem_q      <= '0;
      if (bag_size_q == '0) begin
        divisor_q <= bdwr_pkg::CntW'(bdwr_pkg::PlainMod);
      end else if (count_q == '0) begin
        divisor_q <= eff_bag;
      end else begin
        divisor_q <= count_q;
      end
    end else if (cmd_i.div_step) begin
      dividend_q <= {dividend_q[bdwr_pkg::RndW-3:0], 2'b00};
      rem_q      <= rem_d;
    end
    if (cmd_i.finish) begin
      if (plain_q) begin
        symbol_q <= rem_q[bdwr_pkg::SymW-1:0];
      end else if (eff_q == '0) begin
        symbol_q <= drawn;
      end else begin
        symbol_q <= issued;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = symbol_q;

endmodule

/* design/bag_draw_without_replacement.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bag draw without replacement
// Bag randomiser with a preview queue, built as controller plus datapath.
// ----------------------------------------------------------------------------
// A word is registered at the output once the remainder iterations and the
// selection are done; it waits only while an earlier output word is stalled.
// A new draw is taken only after the previous word is issued. The remainder
// unit retires two bits of the 16-bit random value per cycle.
// Reset clears the bag, its count and the preview queue at once; the bag size
// returns to 7 and the queue length to 5. There is no clearing pass.
module bag_draw_without_replacement (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bdwr_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bdwr_pkg::CfgW-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bdwr_pkg::RndW-1:0]         random_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bdwr_pkg::SymW-1:0]         symbol_o
);

  bdwr_pkg::ctrl_cmd_t  cmd;
  bdwr_pkg::ctrl_stat_t stat;

  bdwr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bdwr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .random_value_i (random_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .symbol_o       (symbol_o),
    .cmd_i          (cmd),
    .stat_o         (stat)
  );

endmodule

/* design/bdwr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bag draw port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module bdwr_port_checks (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_i,
  input logic                          out_valid_i,
  input logic                          out_stall_i,
  input logic [bdwr_pkg::SymW-1:0]     symbol_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("Output word dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(symbol_i))
    else $error("Output word changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i ##1 in_stall_i)
    else $error("Input taken again while a draw is in progress.");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> !$rose(out_valid_i))
    else $error("Result issued before the remainder was ready.");

endmodule

bind bag_draw_without_replacement bdwr_port_checks u_bdwr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .symbol_i    (symbol_o)
);

/* verif/bdwr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bag draw checker
// Watches the configuration port and both word channels of the bag
// randomiser. It keeps its own copy of the registers, the bag and the preview
// queue, predicts the symbol for every accepted draw and compares each
// accepted output word with the oldest prediction.
// ----------------------------------------------------------------------------
module bdwr_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bdwr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bdwr_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [bdwr_pkg::RndW-1:0]    random_value_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [bdwr_pkg::SymW-1:0]    symbol_i,
  output int                           error_count_o,
  output int                           pending_o,
  output int                           checked_o
);

  logic [bdwr_pkg::CfgW-1:0]   bag_size_q;
  logic [bdwr_pkg::CfgW-1:0]   queue_len_q;
  logic [bdwr_pkg::MaxBag-1:0] bag_mask;
  logic [bdwr_pkg::CfgW-1:0]   bag_count;
  logic [bdwr_pkg::SymW-1:0]   preview [bdwr_pkg::MaxQueue];
  logic [bdwr_pkg::SymW-1:0]   expected_symbols [$];
  logic [bdwr_pkg::SymW-1:0]   predicted;
  logic [bdwr_pkg::SymW-1:0]   oldest;

  task automatic draw_symbol(input logic [bdwr_pkg::RndW-1:0] rnd,
                             output logic [bdwr_pkg::SymW-1:0] issued);
    int eff_bag;
    int eff_q;
    int pick;
    logic [bdwr_pkg::SymW-1:0] drawn;
    if (bag_size_q == '0) begin
      issued = bdwr_pkg::SymW'(int'(rnd) % bdwr_pkg::PlainMod);
    end else begin
      eff_bag = (int'(bag_size_q) > bdwr_pkg::MaxBag) ? bdwr_pkg::MaxBag : int'(bag_size_q);
      eff_q   = (int'(queue_len_q) > bdwr_pkg::MaxQueue) ? bdwr_pkg::MaxQueue
                                                         : int'(queue_len_q);
      if (bag_count == '0) begin
        bag_mask  = bdwr_pkg::MaxBag'((1 << eff_bag) - 1);
        bag_count = bdwr_pkg::CfgW'(eff_bag);
      end
      pick  = int'(rnd) % int'(bag_count);
      drawn = '0;
      for (int i = 0; i < eff_bag; i++) begin
        if (bag_mask[i]) begin
          if (pick == 0) begin
            drawn       = bdwr_pkg::SymW'(i);
            bag_mask[i] = 1'b0;
            break;
          end
          pick--;
        end
      end
      bag_count = bag_count - bdwr_pkg::CfgW'(1);
      if (eff_q == 0) begin
        issued = drawn;
      end else begin
        issued = preview[0];
        for (int i = 1; i < eff_q; i++) begin
          preview[i-1] = preview[i];
        end
        preview[eff_q-1] = drawn;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bag_size_q  = bdwr_pkg::BagSizeReset;
      queue_len_q = bdwr_pkg::QueueLengthReset;
      bag_mask    = '0;
      bag_count   = '0;
      for (int i = 0; i < bdwr_pkg::MaxQueue; i++) begin
        preview[i] = '0;
      end
      expected_symbols.delete();
      pending_o     = 0;
      error_count_o = 0;
      checked_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bdwr_pkg::RegBagSize:     bag_size_q  = cfg_wdata_i;
          bdwr_pkg::RegQueueLength: queue_len_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        draw_symbol(random_value_i, predicted);
        expected_symbols.push_back(predicted);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_symbols.size() == 0) begin
          $error("symbol: no word expected, got %0d", symbol_i);
          error_count_o++;
        end else begin
          oldest = expected_symbols.pop_front();
          checked_o++;
          if (symbol_i !== oldest) begin
            $error("symbol: expected %0d, got %0d", oldest, symbol_i);
            error_count_o++;
          end
        end
      end
      pending_o = expected_symbols.size();
    end
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bag draw testbench
// Drives draw requests into the bag randomiser through a directed opening and
// a series of randomly configured phases, with bursty input, varied output
// stalls and register writes between drained phases. The checker beside the
// block predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb;

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 12;
  localparam int DrainCycles  = 20;
  localparam int RandomPhases = 10;
  localparam int PhaseItems   = 40;

  typedef enum int {
    StallNone,
    StallRandom,
    StallLong,
    StallPeriodic
  } stall_mode_e;

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         cfg_we_i       = 1'b0;
  logic [bdwr_pkg::CfgIdxW-1:0] cfg_idx_i      = '0;
  logic [bdwr_pkg::CfgW-1:0]    cfg_wdata_i    = '0;
  logic                         in_valid_i     = 1'b0;
  logic                         in_stall_o;
  logic [bdwr_pkg::RndW-1:0]    random_value_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i    = 1'b0;
  logic [bdwr_pkg::SymW-1:0]    symbol_o;

  int          error_count;
  int          pending;
  int          checked;
  int          cycle_count = 0;
  int          draws_sent  = 0;
  int          configs     = 0;
  int          burst_left  = 1;
  bit          gaps_on     = 1'b0;
  stall_mode_e stall_mode  = StallNone;
  int          stall_run   = 0;
  logic        stall_level = 1'b0;

  bag_draw_without_replacement u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .random_value_i (random_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .symbol_o       (symbol_o)
  );

  bdwr_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .random_value_i (random_value_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .symbol_i       (symbol_o),
    .error_count_o  (error_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    case (stall_mode)
      StallNone:   out_stall_i <= 1'b0;
      StallRandom: out_stall_i <= ($urandom_range(0, 99) < 30);
      StallLong: begin
        if (stall_run == 0) begin
          stall_run   = $urandom_range(1, 30);
          stall_level = ~stall_level;
        end
        stall_run--;
        out_stall_i <= stall_level;
      end
      default:     out_stall_i <= ((cycle_count % 5) < 2);
    endcase
  end

  task automatic send_draw(input logic [bdwr_pkg::RndW-1:0] value);
    bit accepted;
    in_valid_i     <= 1'b1;
    random_value_i <= value;
    accepted = 1'b0;
    while (!accepted) begin
      @(posedge clk_i);
      accepted = !in_stall_o;
      @(negedge clk_i);
    end
    draws_sent++;
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_config(input logic [bdwr_pkg::CfgW-1:0] bag,
                              input logic [bdwr_pkg::CfgW-1:0] qlen);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= bdwr_pkg::RegBagSize;
    cfg_wdata_i <= bag;
    @(negedge clk_i);
    cfg_idx_i   <= bdwr_pkg::RegQueueLength;
    cfg_wdata_i <= qlen;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
    configs++;
  endtask

  function automatic logic [bdwr_pkg::RndW-1:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return bdwr_pkg::RndW'($urandom_range(0, 65535));
  endfunction

  initial begin
    logic [bdwr_pkg::CfgW-1:0] bag;
    logic [bdwr_pkg::CfgW-1:0] qlen;
    int r;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Opening draws run with the register values left by reset.
    send_draw('0);
    send_draw('1);
    send_draw(bdwr_pkg::RndW'(12345));

    // A bag size of zero gives plain random symbols and leaves the bag alone.
    write_config('0, bdwr_pkg::CfgW'(5));
    send_draw('1);
    send_draw('0);
    send_draw(bdwr_pkg::RndW'(6));
    send_draw(bdwr_pkg::RndW'(7));

    write_config(bdwr_pkg::CfgW'(8), '0);
    send_draw('1);
    send_draw('0);
    send_draw(bdwr_pkg::RndW'(1));
    send_draw(bdwr_pkg::RndW'(32768));

    // Oversized bag and queue settings are clipped to their maxima.
    write_config('1, '1);
    send_draw('1);
    send_draw('0);
    send_draw(bdwr_pkg::RndW'(3));
    send_draw(bdwr_pkg::RndW'(9));

    write_config(bdwr_pkg::CfgW'(8), bdwr_pkg::CfgW'(8));
    send_draw(bdwr_pkg::RndW'(2));

    // Shrinking the bag while it still holds symbols leaves it unrefilled,
    // so the scan may find nothing and yield symbol zero.
    write_config(bdwr_pkg::CfgW'(3), '0);
    send_draw('1);
    send_draw('0);
    send_draw(bdwr_pkg::RndW'(1));
    send_draw('1);

    write_config(bdwr_pkg::CfgW'(1), bdwr_pkg::CfgW'(1));
    send_draw(bdwr_pkg::RndW'(5));
    send_draw('1);

    for (int phase = 0; phase < RandomPhases; phase++) begin
      r = $urandom_range(0, 9);
      if (r == 0) bag = '0;
      else if (r == 9) bag = bdwr_pkg::CfgW'($urandom_range(9, 15));
      else bag = bdwr_pkg::CfgW'($urandom_range(1, 8));
      qlen = ($urandom_range(0, 4) == 0) ? bdwr_pkg::CfgW'($urandom_range(9, 15))
                                         : bdwr_pkg::CfgW'($urandom_range(0, 8));
      write_config(bag, qlen);
      if (phase == 0) begin
        gaps_on    = 1'b0;
        stall_mode = StallNone;
      end else begin
        gaps_on    = ($urandom_range(0, 3) != 0);
        stall_mode = stall_mode_e'($urandom_range(0, 3));
      end
      burst_left = $urandom_range(1, 12);
      for (int n = 0; n < PhaseItems; n++) begin
        if (phase == RandomPhases / 2 && n == PhaseItems / 2) begin
          wait_drained();
        end
        send_draw(pick_value());
      end
    end

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);

    $display("Summary: %0d draws sent and %0d symbols checked over %0d register settings.",
             draws_sent, checked, configs);
    $display("Covered plain random mode, clipped sizes, stale bags and varied stalls.");
    if (error_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
design/bdwr_pkg.sv
design/bdwr_ctrl.sv
design/bdwr_dp.sv
design/bag_draw_without_replacement.sv
design/bdwr_checker.sv
verif/bdwr_checker.sv
verif/tb.sv
